@@ sv/igsd_pkg.sv @@
// Shared types and constants of the group-quantized int4 dot-product block.
// Used by the lane, merge, scale stages and the top level; depends on nothing.
package igsd_pkg;

  localparam int ACT_W    = 16;
  localparam int SCALE_W  = 16;
  localparam int NIB_W    = 4;
  localparam int PROD_W   = NIB_W + ACT_W;
  localparam int PAIR_W   = PROD_W + 1;
  localparam int SUM_W    = 32;
  localparam int TOTAL_W  = 48;
  localparam int ROWLEN_W = 13;
  localparam int GRPSZ_W  = 9;
  localparam int CFG_W    = 13;
  localparam int CFGIDX_W = 1;

  // Flipping the top bit of a 4-bit code gives code minus 8 as a signed nibble.
  localparam logic [NIB_W-1:0] NIB_BIAS_FLIP = 4'h8;

  typedef enum logic [CFGIDX_W-1:0] {
    REG_ROW_LENGTH = 1'b0,
    REG_GROUP_SIZE = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic valid;
    logic grp_end;
    logic row_end;
  } igsd_ctl_t;

endpackage

@@ sv/int4_group_scaled_dot_product.sv @@
// Top level of the group-quantized int4 dot-product row engine.
// Depends on igsd_pkg, igsd_lane, igsd_merge and igsd_scale.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall   weight_byte, act_even, act_odd, group_scale
//   out_     output     out_valid/out_stall row_result, saturated
//   cfg_     input      cfg_we              cfg_index, cfg_wdata
//
// One word is accepted every cycle unless a stalled result holds the pipeline; two lanes take the even and odd nibble.
// The row result passes the lane, group merge, scale multiply and row add registers in
// that order; the lane register loads at the edge that accepts the row's last word.
// A stalled result freezes the whole pipeline and raises in_stall.
// Synchronous active-low reset clears counters, sums and valids; registers
// come up as row_length 4096 and group_size 32.
module int4_group_scaled_dot_product #(
  parameter int MAX_ROW   = 4096,
  parameter int MAX_GROUP = 256
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [7:0]                           in_weight_byte,
  input  logic signed [igsd_pkg::ACT_W-1:0]    in_act_even,
  input  logic signed [igsd_pkg::ACT_W-1:0]    in_act_odd,
  input  logic signed [igsd_pkg::SCALE_W-1:0]  in_group_scale,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [igsd_pkg::TOTAL_W-1:0]  out_row_result,
  output logic                                 out_saturated,
  input  logic                                 cfg_we,
  input  logic [igsd_pkg::CFGIDX_W-1:0]        cfg_index,
  input  logic [igsd_pkg::CFG_W-1:0]           cfg_wdata
);
  import igsd_pkg::*;

  localparam int PW = $clog2(MAX_ROW + 1);
  localparam int LW = (PW > ROWLEN_W) ? PW : ROWLEN_W;
  localparam int GW = $clog2(MAX_GROUP + 1);
  localparam int HW = (GW > GRPSZ_W) ? GW : GRPSZ_W;

  logic [ROWLEN_W-1:0]      row_length_r;
  logic [GRPSZ_W-1:0]       group_size_r;
  logic [PW-1:0]            pos_r;
  logic [PW-1:0]            pos_nxt;
  logic [GW-1:0]            gpos_r;
  logic [GW-1:0]            gpos_nxt;
  logic signed [SCALE_W-1:0] held_r;
  logic signed [SCALE_W-1:0] scale_cur;

  logic [LW:0]              rl_eff;
  logic [LW:0]              pos_ext;
  logic [LW:0]              pos_new;
  logic [HW:0]              gs_eff;
  logic [HW:0]              gpos_new;
  logic                     take2;
  logic                     row_end;
  logic                     grp_end;
  logic                     adv;
  logic                     accept;
  logic signed [ACT_W-1:0]  act_odd_g;

  igsd_ctl_t                 ctl1_r;
  logic signed [SCALE_W-1:0] scale1_r;
  logic signed [PROD_W-1:0]  prod_even;
  logic signed [PROD_W-1:0]  prod_odd;
  igsd_ctl_t                 ctl2;
  logic signed [SUM_W-1:0]   grp_sum2;
  logic signed [SCALE_W-1:0] scale2;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;
  assign accept   = in_valid && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_length_r <= ROWLEN_W'(4096);
      group_size_r <= GRPSZ_W'(32);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ROW_LENGTH: row_length_r <= cfg_wdata[ROWLEN_W-1:0];
        REG_GROUP_SIZE: group_size_r <= cfg_wdata[GRPSZ_W-1:0];
      endcase
    end
  end

  always_comb begin
    rl_eff = (LW+1)'(row_length_r);
    if (rl_eff == '0) begin
      rl_eff = (LW+1)'(1);
    end else if (rl_eff > (LW+1)'(MAX_ROW)) begin
      rl_eff = (LW+1)'(MAX_ROW);
    end

    gs_eff = (HW+1)'(group_size_r);
    if (gs_eff > (HW+1)'(MAX_GROUP)) begin
      gs_eff = (HW+1)'(MAX_GROUP);
    end
    gs_eff[0] = 1'b0;
    if (gs_eff < (HW+1)'(2)) begin
      gs_eff = (HW+1)'(2);
    end

    pos_ext  = (LW+1)'(pos_r);
    // A single element left in the row is an odd tail: low nibble only.
    take2    = (pos_ext < rl_eff) && (pos_ext + (LW+1)'(2) <= rl_eff);
    pos_new  = pos_ext + (take2 ? (LW+1)'(2) : (LW+1)'(1));
    gpos_new = (HW+1)'(gpos_r) + (take2 ? (HW+1)'(2) : (HW+1)'(1));
    row_end  = pos_new >= rl_eff;
    grp_end  = row_end || (gpos_new >= gs_eff);
    pos_nxt  = row_end ? '0 : pos_new[PW-1:0];
    gpos_nxt = grp_end ? '0 : gpos_new[GW-1:0];

    scale_cur = (gpos_r == '0) ? in_group_scale : held_r;
    act_odd_g = take2 ? in_act_odd : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      gpos_r <= '0;
      held_r <= '0;
      ctl1_r <= '0;
    end else begin
      if (adv) begin
        ctl1_r.valid   <= accept;
        ctl1_r.grp_end <= grp_end;
        ctl1_r.row_end <= row_end;
      end
      if (accept) begin
        pos_r  <= pos_nxt;
        gpos_r <= gpos_nxt;
        held_r <= scale_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      scale1_r <= scale_cur;
    end
  end

  igsd_lane u_lane_even (
    .clk  (clk),
    .adv  (adv),
    .code (in_weight_byte[NIB_W-1:0]),
    .act  (in_act_even),
    .prod (prod_even)
  );

  igsd_lane u_lane_odd (
    .clk  (clk),
    .adv  (adv),
    .code (in_weight_byte[2*NIB_W-1:NIB_W]),
    .act  (act_odd_g),
    .prod (prod_odd)
  );

  igsd_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .ctl_in    (ctl1_r),
    .prod_even (prod_even),
    .prod_odd  (prod_odd),
    .scale_in  (scale1_r),
    .ctl_out   (ctl2),
    .grp_sum   (grp_sum2),
    .scale_out (scale2)
  );

  igsd_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .ctl_in    (ctl2),
    .grp_sum   (grp_sum2),
    .scale     (scale2),
    .res_valid (out_valid),
    .res_total (out_row_result),
    .res_clip  (out_saturated)
  );

endmodule

@@ sv/igsd_lane.sv @@
// One multiply lane: a signed weight nibble times a Q3.12 activation, registered.
// Depends on igsd_pkg for widths.
module igsd_lane (
  input  logic                                clk,
  input  logic                                adv,
  input  logic [igsd_pkg::NIB_W-1:0]          code,
  input  logic signed [igsd_pkg::ACT_W-1:0]   act,
  output logic signed [igsd_pkg::PROD_W-1:0]  prod
);
  import igsd_pkg::*;

  logic signed [NIB_W-1:0]  weight;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] prod_r;

  always_comb begin
    weight   = signed'(code ^ NIB_BIAS_FLIP);
    prod_nxt = weight * act;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule

@@ sv/igsd_merge.sv @@
// Merge stage: adds the two lane products and accumulates the group sum.
// At a group end the finished sum and its scale move on. Depends on igsd_pkg.
module igsd_merge (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  igsd_pkg::igsd_ctl_t                 ctl_in,
  input  logic signed [igsd_pkg::PROD_W-1:0]  prod_even,
  input  logic signed [igsd_pkg::PROD_W-1:0]  prod_odd,
  input  logic signed [igsd_pkg::SCALE_W-1:0] scale_in,
  output igsd_pkg::igsd_ctl_t                 ctl_out,
  output logic signed [igsd_pkg::SUM_W-1:0]   grp_sum,
  output logic signed [igsd_pkg::SCALE_W-1:0] scale_out
);
  import igsd_pkg::*;

  logic signed [PAIR_W-1:0]  pair;
  logic signed [SUM_W-1:0]   acc;
  logic signed [SUM_W-1:0]   part_r;
  igsd_ctl_t                 ctl_r;
  logic signed [SUM_W-1:0]   sum_r;
  logic signed [SCALE_W-1:0] scale_r;

  always_comb begin
    pair = PAIR_W'(prod_even) + PAIR_W'(prod_odd);
    // The group sum wraps at 32 bits.
    acc  = part_r + SUM_W'(pair);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_r <= '0;
      ctl_r  <= '0;
    end else if (adv) begin
      ctl_r.valid   <= ctl_in.valid && ctl_in.grp_end;
      ctl_r.grp_end <= ctl_in.grp_end;
      ctl_r.row_end <= ctl_in.row_end;
      if (ctl_in.valid) begin
        part_r <= ctl_in.grp_end ? '0 : acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && ctl_in.valid && ctl_in.grp_end) begin
      sum_r   <= acc;
      scale_r <= scale_in;
    end
  end

  assign ctl_out   = ctl_r;
  assign grp_sum   = sum_r;
  assign scale_out = scale_r;

endmodule

@@ sv/igsd_scale.sv @@
// Scale stage: group sum times scale, then saturating add into the row total.
// Holds the output register of the result channel. Depends on igsd_pkg.
module igsd_scale (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 adv,
  input  igsd_pkg::igsd_ctl_t                  ctl_in,
  input  logic signed [igsd_pkg::SUM_W-1:0]    grp_sum,
  input  logic signed [igsd_pkg::SCALE_W-1:0]  scale,
  output logic                                 res_valid,
  output logic signed [igsd_pkg::TOTAL_W-1:0]  res_total,
  output logic                                 res_clip
);
  import igsd_pkg::*;

  localparam logic signed [TOTAL_W-1:0] TOTAL_MAX = {1'b0, {(TOTAL_W-1){1'b1}}};
  localparam logic signed [TOTAL_W-1:0] TOTAL_MIN = {1'b1, {(TOTAL_W-1){1'b0}}};

  logic                       v3_r;
  logic                       rend3_r;
  logic signed [TOTAL_W-1:0]  prod3_r;
  logic signed [TOTAL_W-1:0]  total_r;
  logic                       clip_r;
  logic signed [TOTAL_W:0]    sum_wide;
  logic signed [TOTAL_W-1:0]  total_nxt;
  logic                       ovf;
  logic                       out_valid_r;
  logic signed [TOTAL_W-1:0]  out_total_r;
  logic                       out_clip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r    <= 1'b0;
      rend3_r <= 1'b0;
    end else if (adv) begin
      v3_r    <= ctl_in.valid;
      rend3_r <= ctl_in.row_end;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && ctl_in.valid) begin
      prod3_r <= TOTAL_W'(grp_sum) * TOTAL_W'(scale);
    end
  end

  always_comb begin
    sum_wide = (TOTAL_W+1)'(total_r) + (TOTAL_W+1)'(prod3_r);
    ovf      = sum_wide[TOTAL_W] != sum_wide[TOTAL_W-1];
    if (!ovf) begin
      total_nxt = sum_wide[TOTAL_W-1:0];
    end else if (sum_wide[TOTAL_W]) begin
      total_nxt = TOTAL_MIN;
    end else begin
      total_nxt = TOTAL_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      clip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v3_r && rend3_r;
      if (v3_r) begin
        if (rend3_r) begin
          total_r <= '0;
          clip_r  <= 1'b0;
        end else begin
          total_r <= total_nxt;
          clip_r  <= clip_r | ovf;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v3_r && rend3_r) begin
      out_total_r <= total_nxt;
      out_clip_r  <= clip_r | ovf;
    end
  end

  assign res_valid = out_valid_r;
  assign res_total = out_total_r;
  assign res_clip  = out_clip_r;

endmodule

@@ sv/igsd_checker.sv @@
// Port-level checks of the dot-product block, bound to its top level.
// Depends on igsd_pkg and int4_group_scaled_dot_product.
module igsd_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [igsd_pkg::TOTAL_W-1:0] out_row_result,
  input logic                                out_saturated
);
  import igsd_pkg::*;

  // A waiting result word keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_row_result)
                               && $stable(out_saturated))
    else $error("result word changed while stalled");

  // The pipeline freezes behind a stalled result, so no input may be taken.
  a_back_pressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while a result is stalled");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Without a pending result the block never stalls its input.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with no result pending");

endmodule

bind int4_group_scaled_dot_product igsd_checker u_igsd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_row_result (out_row_result),
  .out_saturated  (out_saturated)
);

@@ test/int4_group_scaled_dot_product_tb.sv @@
// Self-checking testbench for the group-quantized int4 row dot-product block.
// Needs igsd_pkg and int4_group_scaled_dot_product; a scoreboard class predicts each row total.
`timescale 1ns / 100ps

module int4_group_scaled_dot_product_tb;
  import igsd_pkg::*;

  localparam int     MAX_ROW     = 4096;
  localparam int     MAX_GROUP   = 256;
  localparam int     NIB_OFFSET  = 8;
  localparam int     SETTLE_CYC  = 8;
  localparam int     LONG_HOLD   = 200;
  localparam int     RANDOM_WORDS = 900;
  localparam longint TOTAL_MAX   = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint TOTAL_MIN   = -TOTAL_MAX - 1;

  typedef struct packed {
    logic [TOTAL_W-1:0] row_result;
    logic               saturated;
  } row_word_t;

  // Tracks the row and group position the block should be at and holds the
  // row totals that are still to come out.
  class row_total_board;
    logic [ROWLEN_W-1:0] row_length_reg;
    logic [GRPSZ_W-1:0]  group_size_reg;
    int unsigned         elem_pos;
    int unsigned         grp_pos;
    int                  grp_partial;
    longint              held_scale;
    longint              row_total;
    logic                clip;
    row_word_t           pending_rows[$];
    int                  mismatches;

    function new();
      row_length_reg = ROWLEN_W'(4096);
      group_size_reg = GRPSZ_W'(32);
      elem_pos = 0;
      grp_pos = 0;
      grp_partial = 0;
      held_scale = 0;
      row_total = 0;
      clip = 1'b0;
      mismatches = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_W-1:0] data);
      if (idx == REG_ROW_LENGTH) row_length_reg = data[ROWLEN_W-1:0];
      else group_size_reg = data[GRPSZ_W-1:0];
    endfunction

    function void note_word(logic [7:0] wb, logic signed [ACT_W-1:0] ae,
                            logic signed [ACT_W-1:0] ao,
                            logic signed [SCALE_W-1:0] sc);
      int unsigned rl, gs, take;
      longint      lo, hi, pair, t;
      bit          row_end, grp_end;
      rl = row_length_reg;
      if (rl == 0) rl = 1;
      if (rl > MAX_ROW) rl = MAX_ROW;
      gs = group_size_reg;
      if (gs > MAX_GROUP) gs = MAX_GROUP;
      gs = gs & ~32'd1;
      if (gs < 2) gs = 2;
      lo = longint'(int'(wb[3:0]) - NIB_OFFSET);
      hi = longint'(int'(wb[7:4]) - NIB_OFFSET);
      if (grp_pos == 0) held_scale = longint'(sc);
      // Only the low nibble counts when a single element of the row is left.
      if (elem_pos < rl && rl - elem_pos >= 2) begin
        pair = lo * longint'(ae) + hi * longint'(ao);
        take = 2;
      end else begin
        pair = lo * longint'(ae);
        take = 1;
      end
      grp_partial = int'(longint'(grp_partial) + pair);
      elem_pos += take;
      grp_pos += take;
      row_end = elem_pos >= rl;
      grp_end = row_end || grp_pos >= gs;
      if (grp_end) begin
        t = row_total + longint'(grp_partial) * held_scale;
        if (t > TOTAL_MAX) begin
          t = TOTAL_MAX;
          clip = 1'b1;
        end
        if (t < TOTAL_MIN) begin
          t = TOTAL_MIN;
          clip = 1'b1;
        end
        row_total = t;
        grp_partial = 0;
        grp_pos = 0;
      end
      if (row_end) begin
        pending_rows.push_back('{row_result: row_total[TOTAL_W-1:0], saturated: clip});
        elem_pos = 0;
        grp_pos = 0;
        grp_partial = 0;
        held_scale = 0;
        row_total = 0;
        clip = 1'b0;
      end
    endfunction

    function void check_row(logic [TOTAL_W-1:0] result, logic sat);
      row_word_t exp_row;
      if (pending_rows.size() == 0) begin
        $error("row_result: no row expected, actual %h saturated %b", result, sat);
        mismatches++;
        return;
      end
      exp_row = pending_rows.pop_front();
      if (result !== exp_row.row_result) begin
        $error("row_result: expected %h actual %h", exp_row.row_result, result);
        mismatches++;
      end
      if (sat !== exp_row.saturated) begin
        $error("saturated: expected %b actual %b", exp_row.saturated, sat);
        mismatches++;
      end
    endfunction

    function int pending();
      return pending_rows.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [7:0]                in_weight_byte = '0;
  logic signed [ACT_W-1:0]   in_act_even = '0;
  logic signed [ACT_W-1:0]   in_act_odd = '0;
  logic signed [SCALE_W-1:0] in_group_scale = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [TOTAL_W-1:0] out_row_result;
  logic                      out_saturated;
  logic                      cfg_we = 1'b0;
  logic [CFGIDX_W-1:0]       cfg_index = '0;
  logic [CFG_W-1:0]          cfg_wdata = '0;

  bit sender_idles = 1'b1;
  bit receiver_idles = 1'b1;
  bit hold_next_result = 1'b0;

  row_total_board board = new();

  always #5 clk = ~clk;

  int4_group_scaled_dot_product dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_weight_byte (in_weight_byte),
    .in_act_even    (in_act_even),
    .in_act_odd     (in_act_odd),
    .in_group_scale (in_group_scale),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_row_result (out_row_result),
    .out_saturated  (out_saturated),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_word(input logic [7:0] wb, input logic [15:0] ae,
                           input logic [15:0] ao, input logic [15:0] sc);
    int gap;
    gap = sender_idles ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_weight_byte <= wb;
    in_act_even <= ae;
    in_act_odd <= ao;
    in_group_scale <= sc;
    do @(posedge clk); while (in_stall);
    board.note_word(wb, ae, ao, sc);
  endtask

  // Drops valid, waits for every pending row and lets the pipeline settle; a partial row stays open.
  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic set_regs(input bit do_rl, input logic [CFG_W-1:0] rl_data,
                          input bit do_gs, input logic [CFG_W-1:0] gs_data);
    if (do_rl) begin
      cfg_we <= 1'b1;
      cfg_index <= REG_ROW_LENGTH;
      cfg_wdata <= rl_data;
      @(posedge clk);
      board.write_reg(REG_ROW_LENGTH, rl_data);
    end
    if (do_gs) begin
      cfg_we <= 1'b1;
      cfg_index <= REG_GROUP_SIZE;
      cfg_wdata <= gs_data;
      @(posedge clk);
      board.write_reg(REG_GROUP_SIZE, gs_data);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_random(input int count);
    repeat (count) send_word(8'($urandom), pick_sample(), pick_sample(), pick_sample());
  endtask

  // Result side: out_stall holds each word off once it shows up, for a random gap or LONG_HOLD.
  initial begin
    int gap;
    wait (rst_n);
    forever begin
      if (hold_next_result) begin
        gap = LONG_HOLD;
        hold_next_result = 1'b0;
      end else begin
        gap = receiver_idles ? $urandom_range(0, 9) : 0;
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        do @(posedge clk); while (!out_valid);
        repeat (gap - 1) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      board.check_row(out_row_result, out_saturated);
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int random_words;
    int n;
    int pick;
    logic [CFG_W-1:0] rl_data, gs_data;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Under the values the registers come up with these words leave the row
    // open; shortening the row then ends it on a one-element tail.
    send_random(100);
    settle();
    set_regs(1'b1, 13'd3, 1'b0, 13'd0);
    send_word(8'h3B, 16'h7FFF, 16'h8000, 16'h1234);

    // Both registers written above their maximum; the row stays open until
    // the next phase shortens it.
    settle();
    set_regs(1'b1, 13'd8191, 1'b1, 13'h1FFF);
    sender_idles = 1'b0;
    send_random(20);
    sender_idles = 1'b1;

    // One-element rows: a zero row length counts as one, so only the low nibble matters.
    settle();
    set_regs(1'b1, 13'd0, 1'b1, 13'd2);
    send_word(8'h00, 16'h7FFF, 16'h8000, 16'h7FFF);
    send_word(8'hFF, 16'h8000, 16'h7FFF, 16'h8000);
    send_word(8'hF0, 16'h8000, 16'h8000, 16'h8000);
    send_word(8'h88, 16'h1234, 16'h4321, 16'h2000);
    send_word(8'h0F, 16'hFFFF, 16'h0001, 16'hFFFF);

    // Three-element rows end on an odd tail; a group size of one counts as two.
    settle();
    set_regs(1'b1, 13'd3, 1'b1, 13'd1);
    send_word(8'hF0, 16'h7FFF, 16'h8000, 16'h4000);
    send_word(8'h0F, 16'h8000, 16'h7FFF, 16'hC000);
    send_word(8'h7E, 16'h0FFF, 16'hF001, 16'h8000);
    send_word(8'hE1, 16'h7FFF, 16'h7FFF, 16'h7FFF);

    // An odd group size is rounded down to even, so the scale changes every two words.
    settle();
    set_regs(1'b1, 13'd7, 1'b1, 13'd5);
    send_word(8'hFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_word(8'h00, 16'h8000, 16'h8000, 16'h8000);
    send_word(8'h5A, 16'h1000, 16'hF000, 16'h4000);
    send_word(8'hC3, 16'h8000, 16'h1234, 16'h0001);

    // A group size of zero counts as two.
    settle();
    set_regs(1'b0, 13'd0, 1'b1, 13'd0);
    send_word(8'h9F, 16'h4000, 16'hC000, 16'hFFFF);
    send_word(8'h18, 16'h7FFF, 16'h8000, 16'h2000);
    send_word(8'hA5, 16'h0001, 16'hFFFF, 16'h7FFF);
    send_word(8'h3C, 16'h8000, 16'h7FFF, 16'h8000);

    // Back-pressure: two-element rows sent without gaps while the result
    // side holds off long enough for the block to stall its input.
    settle();
    set_regs(1'b1, 13'd2, 1'b1, 13'd2);
    sender_idles = 1'b0;
    hold_next_result = 1'b1;
    send_random(60);
    sender_idles = 1'b1;

    // Random phases; a phase may stop mid-row, so later writes land mid-row too.
    random_words = 0;
    while (random_words < RANDOM_WORDS) begin
      settle();
      pick = $urandom_range(0, 99);
      if (pick < 8) rl_data = 13'd0;
      else if (pick < 60) rl_data = 13'($urandom_range(1, 24));
      else if (pick < 85) rl_data = 13'($urandom_range(25, 120));
      else if (pick < 95) rl_data = 13'($urandom_range(121, 600));
      else rl_data = 13'($urandom_range(4097, 8191));
      pick = $urandom_range(0, 99);
      if (pick < 10) gs_data = 13'($urandom_range(0, 1));
      else if (pick < 50) gs_data = 13'(2 * $urandom_range(1, 8));
      else if (pick < 70) gs_data = 13'($urandom_range(2, 40));
      else if (pick < 85) gs_data = 13'($urandom_range(41, 256));
      else gs_data = 13'($urandom_range(257, 511));
      // Bits above the group size field are don't-care.
      gs_data[CFG_W-1:GRPSZ_W] = 4'($urandom);
      set_regs($urandom_range(0, 3) != 0, rl_data, $urandom_range(0, 3) != 0, gs_data);
      sender_idles = $urandom_range(0, 3) != 0;
      receiver_idles = $urandom_range(0, 3) != 0;
      n = $urandom_range(4, 60);
      send_random(n);
      random_words += n;
    end

    in_valid <= 1'b0;
    while (board.pending() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
